>>> rtl/rsp_packet_receiver_defines.svh
// Assertion macros for the packet receiver.
// Each use expects clk and rst in scope.
`ifndef RSP_PACKET_RECEIVER_DEFINES_SVH
`define RSP_PACKET_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define RSPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define RSPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSPR_ASSERT(lbl, prop, msg)
`define RSPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/rspr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rspr_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 10;
  localparam int NIB_W       = 4;
  localparam int MAX_PAYLOAD = 1023;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] ACK_GOOD  = 8'h2B;
  localparam logic [BYTE_W-1:0] ACK_BAD   = 8'h2D;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 10'd1023;

  // APB map: one register, decoded on address bit 2
  localparam int  APB_ADDR_W = 3;
  localparam int  APB_DATA_W = 32;
  localparam logic REG_PAYLOAD_LIMIT = 1'b0;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    K_BYTE    = 3'd0,
    K_RESTART = 3'd1,
    K_GOOD    = 3'd2,
    K_BAD     = 3'd3,
    K_TRUNC   = 3'd4,
    K_ABORT   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_DOLLAR = 2'd1,
    CLS_HASH   = 2'd2
  } cls_t;

  // classified input item
  typedef struct packed {
    logic              err;
    cls_t              cls;
    logic [BYTE_W-1:0] data;
    logic [NIB_W-1:0]  nibble;
  } token_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] ack_byte;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] frame_sum;
  } result_t;

  // non-hex characters count as zero
  function automatic logic [NIB_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [NIB_W-1:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[NIB_W-1:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[NIB_W-1:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rspr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rspr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_error;

  modport source (output valid, output rx_byte, output link_error, input ready);
  modport sink   (input valid, input rx_byte, input link_error, output ready);
endinterface

interface rspr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic [7:0] ack_byte;
  logic [9:0] frame_length;
  logic [7:0] frame_sum;

  modport source (output valid, output kind, output payload_byte, output ack_byte,
                  output frame_length, output frame_sum, input ready);
  modport sink   (input valid, input kind, input payload_byte, input ack_byte,
                  input frame_length, input frame_sum, output ready);
endinterface

`default_nettype wire

>>> rtl/rspr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rspr_front (
  rspr_in_if.sink           rx,
  input  logic              full,
  output logic              push,
  output rspr_pkg::token_t  tok
);

  assign rx.ready = !full;
  assign push     = rx.valid && !full;

  always_comb begin
    tok.err    = rx.link_error;
    tok.data   = rx.rx_byte;
    tok.nibble = rspr_pkg::hex_value(rx.rx_byte);
    priority if (rx.rx_byte == rspr_pkg::CH_DOLLAR) begin
      tok.cls = rspr_pkg::CLS_DOLLAR;
    end else if (rx.rx_byte == rspr_pkg::CH_HASH) begin
      tok.cls = rspr_pkg::CLS_HASH;
    end else begin
      tok.cls = rspr_pkg::CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rspr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "rsp_packet_receiver_defines.svh"

module rspr_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rspr_pkg::token_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output rspr_pkg::token_t head
);

  rspr_pkg::token_t                  mem [rspr_pkg::QDEPTH];
  logic [rspr_pkg::QPTR_W-1:0]       wr_ptr;
  logic [rspr_pkg::QPTR_W-1:0]       rd_ptr;
  logic [rspr_pkg::QCNT_W-1:0]       count;

  assign full  = (count == rspr_pkg::QCNT_W'(rspr_pkg::QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RSPR_ASSERT(a_count_bound, count <= rspr_pkg::QCNT_W'(rspr_pkg::QDEPTH), "count over depth")
  `RSPR_ASSERT(a_no_underflow, pop |-> (count != '0), "pop from empty queue")
  `RSPR_ASSERT(a_no_overflow, push |-> !full, "push into full queue")

endmodule

`default_nettype wire

>>> rtl/rspr_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "rsp_packet_receiver_defines.svh"

module rspr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tok_valid,
  input  rspr_pkg::token_t            tok,
  output logic                        tok_pop,
  input  logic [rspr_pkg::LEN_W-1:0]  limit,
  rspr_out_if.source                  res
);

  rspr_pkg::phase_t                  phase, phase_next;
  logic [rspr_pkg::LEN_W-1:0]        byte_count, byte_count_next;
  logic [rspr_pkg::BYTE_W-1:0]       running_sum, running_sum_next;
  logic [rspr_pkg::NIB_W-1:0]        high_nibble, high_nibble_next;

  logic                              res_valid;
  rspr_pkg::result_t                 res_q, res_d;
  logic                              emit;

  logic [rspr_pkg::LEN_W-1:0]        cnt_inc;
  logic [rspr_pkg::BYTE_W-1:0]       sum_add;
  logic [rspr_pkg::BYTE_W-1:0]       given;
  logic                              at_limit;

  assign tok_pop  = tok_valid && (!res_valid || res.ready);
  assign cnt_inc  = byte_count + 1'b1;
  assign sum_add  = running_sum + tok.data;
  assign given    = {high_nibble, tok.nibble};
  assign at_limit = (byte_count >= limit);

  // next state
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    high_nibble_next = high_nibble;
    if (tok.err) begin
      phase_next       = rspr_pkg::PH_HUNT;
      byte_count_next  = '0;
      running_sum_next = '0;
      high_nibble_next = '0;
    end else begin
      unique case (phase)
        rspr_pkg::PH_HUNT: begin
          if (tok.cls == rspr_pkg::CLS_DOLLAR) begin
            phase_next = rspr_pkg::PH_DATA;
          end
        end
        rspr_pkg::PH_DATA: begin
          priority if (at_limit) begin
            // '$' on the truncating byte opens the next frame
            phase_next = (tok.cls == rspr_pkg::CLS_DOLLAR) ? rspr_pkg::PH_DATA
                                                            : rspr_pkg::PH_HUNT;
            byte_count_next  = '0;
            running_sum_next = '0;
            high_nibble_next = '0;
          end else if (tok.cls == rspr_pkg::CLS_DOLLAR) begin
            byte_count_next  = '0;
            running_sum_next = '0;
            high_nibble_next = '0;
          end else if (tok.cls == rspr_pkg::CLS_HASH) begin
            phase_next = rspr_pkg::PH_HEX1;
          end else begin
            byte_count_next  = cnt_inc;
            running_sum_next = sum_add;
          end
        end
        rspr_pkg::PH_HEX1: begin
          high_nibble_next = tok.nibble;
          phase_next       = rspr_pkg::PH_HEX2;
        end
        rspr_pkg::PH_HEX2: begin
          phase_next       = rspr_pkg::PH_HUNT;
          byte_count_next  = '0;
          running_sum_next = '0;
          high_nibble_next = '0;
        end
      endcase
    end
  end

  // result
  always_comb begin
    emit               = 1'b0;
    res_d.kind         = rspr_pkg::K_BYTE;
    res_d.payload_byte = '0;
    res_d.ack_byte     = '0;
    res_d.frame_length = byte_count;
    res_d.frame_sum    = running_sum;
    if (tok.err) begin
      emit       = 1'b1;
      res_d.kind = rspr_pkg::K_ABORT;
    end else begin
      unique case (phase)
        rspr_pkg::PH_HUNT: begin
          emit = 1'b0;
        end
        rspr_pkg::PH_DATA: begin
          priority if (at_limit) begin
            emit       = 1'b1;
            res_d.kind = rspr_pkg::K_TRUNC;
          end else if (tok.cls == rspr_pkg::CLS_DOLLAR) begin
            emit       = 1'b1;
            res_d.kind = rspr_pkg::K_RESTART;
          end else if (tok.cls == rspr_pkg::CLS_OTHER) begin
            emit               = 1'b1;
            res_d.payload_byte = tok.data;
            res_d.frame_length = cnt_inc;
            res_d.frame_sum    = sum_add;
          end else begin
            emit = 1'b0;
          end
        end
        rspr_pkg::PH_HEX1: begin
          emit = 1'b0;
        end
        rspr_pkg::PH_HEX2: begin
          emit = 1'b1;
          if (given == running_sum) begin
            res_d.kind     = rspr_pkg::K_GOOD;
            res_d.ack_byte = rspr_pkg::ACK_GOOD;
          end else begin
            res_d.kind     = rspr_pkg::K_BAD;
            res_d.ack_byte = rspr_pkg::ACK_BAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rspr_pkg::PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      high_nibble <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (tok_pop) begin
        phase       <= phase_next;
        byte_count  <= byte_count_next;
        running_sum <= running_sum_next;
        high_nibble <= high_nibble_next;
      end
      if (tok_pop && emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      res_q <= res_d;
    end
  end

  assign res.valid        = res_valid;
  assign res.kind         = res_q.kind;
  assign res.payload_byte = res_q.payload_byte;
  assign res.ack_byte     = res_q.ack_byte;
  assign res.frame_length = res_q.frame_length;
  assign res.frame_sum    = res_q.frame_sum;

  `RSPR_ASSERT(a_hunt_clear, (phase == rspr_pkg::PH_HUNT) |-> (byte_count == '0 && running_sum == '0 && high_nibble == '0), "state not cleared while hunting")
  `RSPR_ASSERT(a_ack_kind, res_valid |-> ((res_q.kind == rspr_pkg::K_GOOD) == (res_q.ack_byte == rspr_pkg::ACK_GOOD)), "ack byte does not match result kind")
  `RSPR_ASSERT(a_byte_len, (res_valid && res_q.kind == rspr_pkg::K_BYTE) |-> (res_q.frame_length != '0), "payload byte with zero length")

endmodule

`default_nettype wire

>>> rtl/rsp_packet_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// rx        in   valid/ready          rx_byte[7:0], link_error
// res       out  valid/ready          kind[2:0], payload_byte, ack_byte,
//                                     frame_length[9:0], frame_sum[7:0]
// apb       in   psel/penable/pready  paddr[2:0], pwdata/prdata[31:0]
//
// One rx item per cycle sustained while res is not stalled; front classifies
// the byte into a 4-entry queue, back runs the framing FSM and loads the
// output register. From rx accept to result valid an item passes the queue
// write and then the result register. Items that give no result ('$' while
// hunting, '#', the first checksum hex digit) are still popped by the back
// end. rst is synchronous; limit resets to 1023. Output stall holds the result
// register; rx backs up only once the queue fills (4 items).

module rsp_packet_receiver (
  input  logic                              clk,
  input  logic                              rst,
  rspr_in_if.sink                           rx,
  rspr_out_if.source                        res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rspr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rspr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rspr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [rspr_pkg::LEN_W-1:0] payload_limit;
  logic [rspr_pkg::LEN_W-1:0] eff_limit;
  logic                       reg_sel;

  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_valid;
  rspr_pkg::token_t           q_in;
  rspr_pkg::token_t           q_head;

  // config register: decoded on the word address bit only
  assign pready  = 1'b1;
  assign reg_sel = (paddr[rspr_pkg::APB_ADDR_W-1] == rspr_pkg::REG_PAYLOAD_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= rspr_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      payload_limit <= pwdata[rspr_pkg::LEN_W-1:0];
    end
  end

  assign prdata = reg_sel ? rspr_pkg::APB_DATA_W'(payload_limit) : '0;

  // effective limit: clamp to the build maximum, zero acts as one
  always_comb begin
    eff_limit = payload_limit;
    if (eff_limit > rspr_pkg::LEN_W'(rspr_pkg::MAX_PAYLOAD)) begin
      eff_limit = rspr_pkg::LEN_W'(rspr_pkg::MAX_PAYLOAD);
    end
    if (eff_limit == '0) begin
      eff_limit = rspr_pkg::LEN_W'(1);
    end
  end

  // front: byte classification
  rspr_front u_front (
    .rx   (rx),
    .full (q_full),
    .push (q_push),
    .tok  (q_in)
  );

  // decoupling queue
  rspr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: framing FSM, checksum, output register
  rspr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_head),
    .tok_pop   (q_pop),
    .limit     (eff_limit),
    .res       (res)
  );

endmodule

`default_nettype wire
